### hw/rtl/apsp_pkg.sv
// ----------------------------------------------------------------------------
// apsp_pkg
// shared constants, codes and types of the all-pairs shortest path block
// ----------------------------------------------------------------------------
package apsp_pkg;

    localparam int MAX_NODES = 16;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int ADDR_W    = 2 * NODE_W;
    localparam int DEPTH     = MAX_NODES * MAX_NODES;
    localparam int DIST_W    = 5;
    localparam int CNT_W     = NODE_W + 1;
    localparam int HOP_W     = 4;

    localparam logic [DIST_W-1:0] UNREACH   = 5'd31;
    localparam logic [HOP_W-1:0]  HOP_MAX   = 4'd15;
    localparam logic [NODE_W-1:0] WALK_LAST = 4'd15;
    localparam logic [CNT_W-1:0]  COUNT_MAX = 5'd16;

    localparam logic [1:0] FUNC_EDGE    = 2'd0;
    localparam logic [1:0] FUNC_COMPUTE = 2'd1;
    localparam logic [1:0] FUNC_QUERY   = 2'd2;
    localparam logic [1:0] FUNC_CLEAR   = 2'd3;

    typedef struct packed {
        logic [DIST_W-1:0] cost;
        logic [NODE_W-1:0] pred;
    } entry_t;

    typedef struct packed {
        logic              we;
        logic              clr;
        logic [ADDR_W-1:0] addr;
        entry_t            data;
    } store_wr_t;

endpackage

### hw/rtl/all_pairs_shortest_path.sv
// ----------------------------------------------------------------------------
// all_pairs_shortest_path
// edges of a directed graph go into a distance/predecessor store; compute runs
// the floyd-warshall relaxation, a query returns the path destination first
// ----------------------------------------------------------------------------
// edge load and clear: busy stays low, next command right after
// query: result in the cycle after the transfer when out of range, else after
//   the store read and the output register, then one node per cycle
// compute: writes the diagonal, then for each (k,i) reads dist[i][k] and, when
//   it is reachable, relaxes row i over every j by read-modify-write
// reset: all entries unreachable through cleared valid bits, node_count = 16
module all_pairs_shortest_path (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    func,
    input  logic [apsp_pkg::NODE_W-1:0]   src_node,
    input  logic [apsp_pkg::NODE_W-1:0]   dst_node,
    input  logic                          cfg_we,
    input  logic [apsp_pkg::CNT_W-1:0]    cfg_data,
    output logic                          strobe,
    output logic [apsp_pkg::NODE_W-1:0]   path_node,
    output logic [apsp_pkg::HOP_W-1:0]    hop_distance,
    output logic                          found,
    output logic                          last
);

    logic [apsp_pkg::CNT_W-1:0]      node_count_reg;
    logic [apsp_pkg::CNT_W-1:0]      node_count_next;
    logic [apsp_pkg::CNT_W-1:0]      n_eff;
    apsp_pkg::store_wr_t             wr;
    logic [apsp_pkg::ADDR_W-1:0]     rd_a_addr;
    logic [apsp_pkg::ADDR_W-1:0]     rd_b_addr;
    apsp_pkg::entry_t                rd_a;
    apsp_pkg::entry_t                rd_b;

    assign node_count_next = cfg_we ? cfg_data : node_count_reg;
    assign n_eff = (node_count_reg > apsp_pkg::COUNT_MAX) ? apsp_pkg::COUNT_MAX
                                                           : node_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= apsp_pkg::COUNT_MAX;
        end
        else
        begin
            node_count_reg <= node_count_next;
        end
    end

    apsp_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .n            (n_eff),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .src_node     (src_node),
        .dst_node     (dst_node),
        .wr           (wr),
        .rd_a_addr    (rd_a_addr),
        .rd_b_addr    (rd_b_addr),
        .rd_a         (rd_a),
        .rd_b         (rd_b),
        .strobe       (strobe),
        .path_node    (path_node),
        .hop_distance (hop_distance),
        .found        (found),
        .last         (last)
    );

    apsp_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a      (rd_a),
        .rd_b      (rd_b)
    );

endmodule

### hw/rtl/apsp_store.sv
// ----------------------------------------------------------------------------
// apsp_store
// distance and predecessor memory, one write port, two registered read ports,
// per-entry valid bits so unwritten entries read as unreachable
// ----------------------------------------------------------------------------
module apsp_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  apsp_pkg::store_wr_t           wr,
    input  logic [apsp_pkg::ADDR_W-1:0]   rd_a_addr,
    input  logic [apsp_pkg::ADDR_W-1:0]   rd_b_addr,
    output apsp_pkg::entry_t              rd_a,
    output apsp_pkg::entry_t              rd_b
);

    apsp_pkg::entry_t                mem [apsp_pkg::DEPTH];
    apsp_pkg::entry_t                rd_a_reg;
    apsp_pkg::entry_t                rd_b_reg;
    logic [apsp_pkg::DEPTH-1:0]      valid_reg;
    logic                            va_reg;
    logic                            vb_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
        end
        else
        begin
            va_reg <= valid_reg[rd_a_addr];
            vb_reg <= valid_reg[rd_b_addr];
            if (wr.clr)
            begin
                valid_reg <= '0;
            end
            else if (wr.we)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
        end
    end

    always_comb
    begin
        rd_a.cost = va_reg ? rd_a_reg.cost : apsp_pkg::UNREACH;
        rd_a.pred = va_reg ? rd_a_reg.pred : '0;
        rd_b.cost = vb_reg ? rd_b_reg.cost : apsp_pkg::UNREACH;
        rd_b.pred = vb_reg ? rd_b_reg.pred : '0;
    end

endmodule

### hw/rtl/apsp_engine.sv
// ----------------------------------------------------------------------------
// apsp_engine
// command sequencer: edge load, clear, floyd-warshall relaxation as a
// read-modify-write sweep over the store, and the predecessor walk of a query
// ----------------------------------------------------------------------------
module apsp_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [apsp_pkg::CNT_W-1:0]    n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    func,
    input  logic [apsp_pkg::NODE_W-1:0]   src_node,
    input  logic [apsp_pkg::NODE_W-1:0]   dst_node,
    output apsp_pkg::store_wr_t           wr,
    output logic [apsp_pkg::ADDR_W-1:0]   rd_a_addr,
    output logic [apsp_pkg::ADDR_W-1:0]   rd_b_addr,
    input  apsp_pkg::entry_t              rd_a,
    input  apsp_pkg::entry_t              rd_b,
    output logic                          strobe,
    output logic [apsp_pkg::NODE_W-1:0]   path_node,
    output logic [apsp_pkg::HOP_W-1:0]    hop_distance,
    output logic                          found,
    output logic                          last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIAG,
        S_IK,
        S_IKD,
        S_J,
        S_QWALK
    } state_t;

    state_t                          state_reg, state_next;
    logic [apsp_pkg::NODE_W-1:0]     k_reg, k_next;
    logic [apsp_pkg::NODE_W-1:0]     i_reg, i_next;
    logic [apsp_pkg::NODE_W-1:0]     j_reg, j_next;
    logic [apsp_pkg::DIST_W-1:0]     dik_reg, dik_next;
    logic [apsp_pkg::NODE_W-1:0]     s_reg, s_next;
    logic [apsp_pkg::NODE_W-1:0]     v_reg, v_next;
    logic [apsp_pkg::HOP_W-1:0]      hops_reg, hops_next;
    logic [apsp_pkg::NODE_W-1:0]     cnt_reg, cnt_next;
    logic                            first_reg, first_next;
    logic                            strobe_reg, strobe_next;
    logic [apsp_pkg::NODE_W-1:0]     path_node_reg, path_node_next;
    logic [apsp_pkg::HOP_W-1:0]      hop_reg, hop_next;
    logic                            found_reg, found_next;
    logic                            last_reg, last_next;

    logic                            accept;
    logic                            src_ok;
    logic                            dst_ok;
    logic                            i_last;
    logic                            j_last;
    logic                            k_last;
    logic [apsp_pkg::DIST_W:0]       sum;
    logic [apsp_pkg::HOP_W-1:0]      hops_cur;
    logic                            done;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign src_ok = ({1'b0, src_node} < n);
    assign dst_ok = ({1'b0, dst_node} < n);
    assign i_last = (({1'b0, i_reg} + 1'b1) == n);
    assign j_last = (({1'b0, j_reg} + 1'b1) == n);
    assign k_last = (({1'b0, k_reg} + 1'b1) == n);
    assign sum    = {1'b0, dik_reg} + {1'b0, rd_a.cost};

    assign strobe       = strobe_reg;
    assign path_node    = path_node_reg;
    assign hop_distance = hop_reg;
    assign found        = found_reg;
    assign last         = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        dik_next       = dik_reg;
        s_next         = s_reg;
        v_next         = v_reg;
        hops_next      = hops_reg;
        cnt_next       = cnt_reg;
        first_next     = first_reg;
        strobe_next    = 1'b0;
        path_node_next = path_node_reg;
        hop_next       = hop_reg;
        found_next     = found_reg;
        last_next      = last_reg;
        wr             = '0;
        rd_a_addr      = {k_reg, j_reg};
        rd_b_addr      = {i_reg, k_reg};
        hops_cur       = hops_reg;
        done           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                rd_b_addr = {src_node, dst_node};
                if (accept)
                begin
                    case (func)
                        apsp_pkg::FUNC_EDGE:
                        begin
                            if (src_ok && dst_ok)
                            begin
                                wr.we        = 1'b1;
                                wr.addr      = {src_node, dst_node};
                                wr.data.cost = apsp_pkg::DIST_W'(1);
                                wr.data.pred = src_node;
                            end
                        end
                        apsp_pkg::FUNC_COMPUTE:
                        begin
                            if (n != '0)
                            begin
                                i_next     = '0;
                                state_next = S_DIAG;
                            end
                        end
                        apsp_pkg::FUNC_QUERY:
                        begin
                            if (src_ok && dst_ok)
                            begin
                                s_next     = src_node;
                                v_next     = dst_node;
                                cnt_next   = '0;
                                first_next = 1'b1;
                                state_next = S_QWALK;
                            end
                            else
                            begin
                                strobe_next    = 1'b1;
                                path_node_next = '0;
                                hop_next       = '0;
                                found_next     = 1'b0;
                                last_next      = 1'b1;
                            end
                        end
                        default:
                        begin
                            wr.clr = 1'b1;
                        end
                    endcase
                end
            end

            S_DIAG:
            begin
                wr.we        = 1'b1;
                wr.addr      = {i_reg, i_reg};
                wr.data.cost = '0;
                wr.data.pred = i_reg;
                if (i_last)
                begin
                    i_next     = '0;
                    k_next     = '0;
                    state_next = S_IK;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end

            S_IK:
            begin
                rd_b_addr  = {i_reg, k_reg};
                state_next = S_IKD;
            end

            S_IKD:
            begin
                if (rd_b.cost != apsp_pkg::UNREACH)
                begin
                    dik_next   = rd_b.cost;
                    j_next     = '0;
                    rd_a_addr  = {k_reg, {apsp_pkg::NODE_W{1'b0}}};
                    rd_b_addr  = {i_reg, {apsp_pkg::NODE_W{1'b0}}};
                    state_next = S_J;
                end
                else if (i_last)
                begin
                    i_next     = '0;
                    k_next     = k_reg + 1'b1;
                    state_next = k_last ? S_IDLE : S_IK;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_IK;
                end
            end

            S_J:
            begin
                if ((rd_a.cost != apsp_pkg::UNREACH) && ({1'b0, rd_b.cost} > sum))
                begin
                    wr.we        = 1'b1;
                    wr.addr      = {i_reg, j_reg};
                    wr.data.cost = sum[apsp_pkg::DIST_W-1:0];
                    wr.data.pred = rd_a.pred;
                end
                if (!j_last)
                begin
                    j_next    = j_reg + 1'b1;
                    rd_a_addr = {k_reg, j_next};
                    rd_b_addr = {i_reg, j_next};
                end
                else if (i_last)
                begin
                    i_next     = '0;
                    k_next     = k_reg + 1'b1;
                    state_next = k_last ? S_IDLE : S_IK;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_IK;
                end
            end

            S_QWALK:
            begin
                rd_b_addr = {s_reg, rd_b.pred};
                if (first_reg && (rd_b.cost == apsp_pkg::UNREACH))
                begin
                    strobe_next    = 1'b1;
                    path_node_next = '0;
                    hop_next       = '0;
                    found_next     = 1'b0;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    if (first_reg)
                    begin
                        hops_cur = (rd_b.cost > {1'b0, apsp_pkg::HOP_MAX}) ?
                                   apsp_pkg::HOP_MAX : rd_b.cost[apsp_pkg::HOP_W-1:0];
                    end
                    done           = (v_reg == s_reg) || (cnt_reg == apsp_pkg::WALK_LAST);
                    hops_next      = hops_cur;
                    strobe_next    = 1'b1;
                    path_node_next = v_reg;
                    hop_next       = hops_cur;
                    found_next     = 1'b1;
                    last_next      = done;
                    first_next     = 1'b0;
                    if (done)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        v_next   = rd_b.pred;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            dik_reg       <= '0;
            s_reg         <= '0;
            v_reg         <= '0;
            hops_reg      <= '0;
            cnt_reg       <= '0;
            first_reg     <= 1'b0;
            strobe_reg    <= 1'b0;
            path_node_reg <= '0;
            hop_reg       <= '0;
            found_reg     <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            dik_reg       <= dik_next;
            s_reg         <= s_next;
            v_reg         <= v_next;
            hops_reg      <= hops_next;
            cnt_reg       <= cnt_next;
            first_reg     <= first_next;
            strobe_reg    <= strobe_next;
            path_node_reg <= path_node_next;
            hop_reg       <= hop_next;
            found_reg     <= found_next;
            last_reg      <= last_next;
        end
    end

endmodule

### tb/apsp_checker.sv
// ----------------------------------------------------------------------------
// apsp_checker
// watches the command and result ports of the shortest path block, keeps its
// own distance and predecessor tables, predicts every path walk and compares
// each result strobe with the oldest predicted step
// ----------------------------------------------------------------------------
module apsp_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [1:0]                    func,
    input  logic [apsp_pkg::NODE_W-1:0]   src_node,
    input  logic [apsp_pkg::NODE_W-1:0]   dst_node,
    input  logic                          cfg_we,
    input  logic [apsp_pkg::CNT_W-1:0]    cfg_data,
    input  logic                          strobe,
    input  logic [apsp_pkg::NODE_W-1:0]   path_node,
    input  logic [apsp_pkg::HOP_W-1:0]    hop_distance,
    input  logic                          found,
    input  logic                          last,
    output int                            errors,
    output int                            pending
);
    import apsp_pkg::*;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [HOP_W-1:0]  hops;
        logic              reached;
        logic              tail;
    } path_step_t;

    logic [DIST_W-1:0] dist_mem [DEPTH];
    logic [NODE_W-1:0] pred_mem [DEPTH];
    logic [CNT_W-1:0]  node_cfg;
    path_step_t        path_steps_due [$];
    path_step_t        seen;
    path_step_t        want;

    function automatic int active_nodes();
        return (node_cfg > COUNT_MAX) ? MAX_NODES : int'(node_cfg);
    endfunction

    function automatic void clear_tables();
        for (int a = 0; a < DEPTH; a++)
        begin
            dist_mem[a] = UNREACH;
            pred_mem[a] = '0;
        end
    endfunction

    function automatic void relax_tables(int n);
        int dik;
        int dkj;
        for (int i = 0; i < n; i++)
        begin
            dist_mem[i * MAX_NODES + i] = '0;
            pred_mem[i * MAX_NODES + i] = NODE_W'(i);
        end
        for (int k = 0; k < n; k++)
        begin
            for (int i = 0; i < n; i++)
            begin
                dik = int'(dist_mem[i * MAX_NODES + k]);
                if (dik != int'(UNREACH))
                begin
                    for (int j = 0; j < n; j++)
                    begin
                        dkj = int'(dist_mem[k * MAX_NODES + j]);
                        if (dkj != int'(UNREACH) &&
                            int'(dist_mem[i * MAX_NODES + j]) > dik + dkj)
                        begin
                            dist_mem[i * MAX_NODES + j] = DIST_W'(dik + dkj);
                            pred_mem[i * MAX_NODES + j] = pred_mem[k * MAX_NODES + j];
                        end
                    end
                end
            end
        end
    endfunction

    // walk from destination back to source, at most sixteen steps
    function automatic void predict_path(int s, int d, int n);
        path_step_t        step;
        logic [DIST_W-1:0] stored;
        logic [HOP_W-1:0]  hops;
        logic              done;
        int                v;
        int                cnt;
        step   = '0;
        stored = dist_mem[s * MAX_NODES + d];
        if (s >= n || d >= n || stored == UNREACH)
        begin
            step.tail = 1'b1;
            path_steps_due = {path_steps_due, step};
            return;
        end
        hops = (stored > DIST_W'(HOP_MAX)) ? HOP_MAX : stored[HOP_W-1:0];
        v    = d;
        cnt  = 0;
        done = 1'b0;
        while (!done)
        begin
            done         = (v == s) || (cnt == MAX_NODES - 1);
            step.node    = NODE_W'(v);
            step.hops    = hops;
            step.reached = 1'b1;
            step.tail    = done;
            path_steps_due = {path_steps_due, step};
            cnt++;
            v = int'(pred_mem[s * MAX_NODES + v]);
        end
    endfunction

    function automatic void note_mismatch(string what, path_step_t exp_step,
                                          path_step_t got_step);
        errors++;
        if (errors <= 10)
        begin
            $write("mismatch at %0t (%s): expected node %0d hops %0d found %0b last %0b",
                   $realtime, what, exp_step.node, exp_step.hops, exp_step.reached,
                   exp_step.tail);
            $display(", got node %0d hops %0d found %0b last %0b",
                     got_step.node, got_step.hops, got_step.reached, got_step.tail);
        end
    endfunction

    initial
    begin
        errors   = 0;
        pending  = 0;
        node_cfg = COUNT_MAX;
        clear_tables();
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_tables();
            node_cfg = COUNT_MAX;
            path_steps_due.delete();
            pending = 0;
        end
        else
        begin
            // results first: a query never answers in its own transfer cycle
            if (strobe === 1'b1)
            begin
                seen = {path_node, hop_distance, found, last};
                if (path_steps_due.size() == 0)
                    note_mismatch("no result pending", '0, seen);
                else
                begin
                    want = path_steps_due.pop_front();
                    if (want !== seen)
                        note_mismatch("wrong result", want, seen);
                end
            end
            if (start && !busy)
            begin
                case (func)
                    FUNC_EDGE:
                    begin
                        if (int'(src_node) < active_nodes() && int'(dst_node) < active_nodes())
                        begin
                            dist_mem[{src_node, dst_node}] = DIST_W'(1);
                            pred_mem[{src_node, dst_node}] = src_node;
                        end
                    end
                    FUNC_COMPUTE:
                        relax_tables(active_nodes());
                    FUNC_QUERY:
                        predict_path(int'(src_node), int'(dst_node), active_nodes());
                    FUNC_CLEAR:
                        clear_tables();
                    default:
                        clear_tables();
                endcase
            end
            // the block uses the old count for a command in the same cycle
            if (cfg_we)
                node_cfg = cfg_data;
            pending = path_steps_due.size();
        end
    end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus for the shortest path block: directed edge, compute, query and
// clear commands, then random graphs, chains and noise over several node
// counts and idle rates; the checker beside the block judges every result
// ----------------------------------------------------------------------------
module tb;
    import apsp_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        func;
    logic [NODE_W-1:0] src_node;
    logic [NODE_W-1:0] dst_node;
    logic              cfg_we;
    logic [CNT_W-1:0]  cfg_data;
    logic              strobe;
    logic [NODE_W-1:0] path_node;
    logic [HOP_W-1:0]  hop_distance;
    logic              found;
    logic              last;

    int errors;
    int pending;
    int idle_pct;
    int node_lim;
    int sent;
    int phase_target;

    int phase_nodes [10] = '{16, 3, 31, 1, 12, 2, 16, 7, 0, 9};
    int phase_idle  [3]  = '{0, 86, 26};

    all_pairs_shortest_path dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .src_node     (src_node),
        .dst_node     (dst_node),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .strobe       (strobe),
        .path_node    (path_node),
        .hop_distance (hop_distance),
        .found        (found),
        .last         (last)
    );

    apsp_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .src_node     (src_node),
        .dst_node     (dst_node),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .strobe       (strobe),
        .path_node    (path_node),
        .hop_distance (hop_distance),
        .found        (found),
        .last         (last),
        .errors       (errors),
        .pending      (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic issue(logic [1:0] f, int s, int d);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start = 1'b0;
        end
        @(negedge clk);
        start    = 1'b1;
        func     = f;
        src_node = NODE_W'(s);
        dst_node = NODE_W'(d);
        // hold until the transfer happens
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
    endtask

    // stop sending until every path step is back and the block is quiet
    task automatic settle();
        @(negedge clk);
        start = 1'b0;
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (6) @(negedge clk);
        while (busy)
            @(negedge clk);
    endtask

    task automatic set_nodes(int v);
        settle();
        cfg_we   = 1'b1;
        cfg_data = CNT_W'(v);
        @(negedge clk);
        cfg_we   = 1'b0;
        node_lim = (v > MAX_NODES) ? MAX_NODES : v;
    endtask

    function automatic int pick();
        if (node_lim == 0 || $urandom_range(9) == 0)
            return $urandom_range(15);
        return $urandom_range(node_lim - 1);
    endfunction

    task automatic graph_case();
        int order [MAX_NODES];
        int t;
        int tmp;
        if ($urandom_range(1) == 1)
            issue(FUNC_CLEAR, $urandom_range(15), $urandom_range(15));
        if (node_lim > 1 && $urandom_range(3) == 0)
        begin
            // one long chain over a shuffled node order
            for (int i = 0; i < node_lim; i++)
                order[i] = i;
            for (int i = node_lim - 1; i > 0; i--)
            begin
                t        = $urandom_range(i);
                tmp      = order[i];
                order[i] = order[t];
                order[t] = tmp;
            end
            for (int i = 0; i < node_lim - 1; i++)
                issue(FUNC_EDGE, order[i], order[i + 1]);
            issue(FUNC_COMPUTE, $urandom_range(15), $urandom_range(15));
            issue(FUNC_QUERY, order[0], order[node_lim - 1]);
        end
        else
        begin
            repeat ($urandom_range(1, 12)) issue(FUNC_EDGE, pick(), pick());
            if ($urandom_range(9) != 0)
                issue(FUNC_COMPUTE, $urandom_range(15), $urandom_range(15));
            if ($urandom_range(4) == 0)
                issue(FUNC_EDGE, pick(), pick());
        end
        repeat ($urandom_range(2, 5)) issue(FUNC_QUERY, pick(), pick());
    endtask

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        func     = FUNC_EDGE;
        src_node = '0;
        dst_node = '0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        idle_pct = 0;
        node_lim = MAX_NODES;
        sent     = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // full node count after reset
        issue(FUNC_EDGE, 0, 1);
        issue(FUNC_EDGE, 1, 2);
        issue(FUNC_EDGE, 2, 15);
        issue(FUNC_EDGE, 3, 3);
        issue(FUNC_QUERY, 0, 1);
        issue(FUNC_QUERY, 0, 2);
        issue(FUNC_QUERY, 3, 3);
        issue(FUNC_COMPUTE, 0, 0);
        issue(FUNC_QUERY, 0, 15);
        issue(FUNC_QUERY, 3, 3);
        issue(FUNC_QUERY, 15, 15);
        issue(FUNC_QUERY, 4, 9);
        issue(FUNC_EDGE, 0, 15);
        issue(FUNC_QUERY, 0, 15);
        issue(FUNC_CLEAR, 15, 15);
        issue(FUNC_QUERY, 0, 1);

        // small node count, edges and queries out of range
        set_nodes(5);
        issue(FUNC_EDGE, 7, 1);
        issue(FUNC_EDGE, 1, 7);
        issue(FUNC_EDGE, 1, 4);
        issue(FUNC_COMPUTE, 0, 0);
        issue(FUNC_QUERY, 1, 4);
        issue(FUNC_QUERY, 1, 9);
        issue(FUNC_QUERY, 9, 1);

        // no node in use
        set_nodes(0);
        issue(FUNC_EDGE, 0, 0);
        issue(FUNC_COMPUTE, 0, 0);
        issue(FUNC_QUERY, 0, 0);

        for (int p = 0; p < 10; p++)
        begin
            set_nodes(phase_nodes[p]);
            idle_pct     = phase_idle[p % 3];
            phase_target = sent + 9;
            while (sent < phase_target)
            begin
                if ($urandom_range(4) == 0)
                    issue(2'($urandom_range(3)), $urandom_range(15), $urandom_range(15));
                else
                    graph_case();
            end
        end

        settle();
        repeat (20) @(negedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #50000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
